// File: rtl/bls_pkg.sv
// bls_pkg: shared types and constants for the bounded list store
// action and status codes, cell command type, controller state type
// no dependencies
`timescale 1ns / 1ps

package bls_pkg;

  localparam int DEF_CAPACITY  = 64;
  localparam int DEF_WORD_BITS = 32;
  localparam int MAX_WORD_BITS = 64;

  localparam int ACTION_BITS = 4;
  localparam int INDEX_BITS  = 8;
  localparam int ELEM_BITS   = 32;
  localparam int CFG_BITS    = 7;
  localparam int FILL_BITS   = 7;

  localparam logic [CFG_BITS-1:0] CFG_RESET = 7'd64;

  // request selector codes
  typedef enum logic [ACTION_BITS-1:0] {
    ACT_SET        = 4'd0,
    ACT_PUSH       = 4'd1,
    ACT_POP        = 4'd2,
    ACT_REM_ORD    = 4'd3,
    ACT_REM_UNORD  = 4'd4,
    ACT_GET        = 4'd5,
    ACT_CLEAR      = 4'd6,
    ACT_ITER_RESET = 4'd7,
    ACT_NEXT       = 4'd8
  } act_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_END   = 2'd3
  } status_t;

  // command broadcast to every cell of the row
  typedef enum logic [2:0] {
    C_HOLD,
    C_WRITE,
    C_SHIFT,
    C_MOVE,
    C_ZERO_LAST,
    C_CLEAR
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     capture;
  } cell_ctrl_t;

  // controller states
  typedef enum logic {
    S_IDLE,
    S_APPLY
  } state_t;

endpackage

// File: rtl/bls_cell.sv
// bls_cell: one entry of the list, with a read tap and a link to its right neighbor
// depends on bls_pkg
`timescale 1ns / 1ps

module bls_cell
  import bls_pkg::*;
#(
  parameter int POS       = 0,
  parameter int IDX_BITS  = 6,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cell_ctrl_t           ctrl,
  input  logic [IDX_BITS-1:0]  wr_addr,
  input  logic [IDX_BITS-1:0]  last_addr,
  input  logic [IDX_BITS-1:0]  rd_addr,
  input  logic [WORD_BITS-1:0] wr_word,
  input  logic [WORD_BITS-1:0] right_data,
  output logic [WORD_BITS-1:0] data,
  output logic [WORD_BITS-1:0] tap
);

  localparam logic [IDX_BITS-1:0] MY_POS = IDX_BITS'(POS);

  logic                 is_wr;
  logic                 is_last;
  logic                 in_tail;
  logic [WORD_BITS-1:0] data_next;

  assign is_wr   = (wr_addr == MY_POS);
  assign is_last = (last_addr == MY_POS);
  assign in_tail = (MY_POS >= wr_addr) && (MY_POS < last_addr);

  // local decision on the broadcast command
  always_comb begin
    data_next = data;
    unique case (ctrl.op)
      C_HOLD: data_next = data;
      C_WRITE: begin
        if (is_wr) data_next = wr_word;
      end
      C_SHIFT: begin
        if (is_last) data_next = '0;
        else if (in_tail) data_next = right_data;
      end
      C_MOVE: begin
        if (is_last) data_next = '0;
        else if (is_wr) data_next = wr_word;
      end
      C_ZERO_LAST: begin
        if (is_last) data_next = '0;
      end
      C_CLEAR: data_next = '0;
      default: data_next = data;
    endcase
  end

  // entry register
  always_ff @(posedge clk) begin
    if (rst) begin
      data <= '0;
    end else begin
      data <= data_next;
    end
  end

  // read tap, zero unless this cell is addressed
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      tap <= (rd_addr == MY_POS) ? data : '0;
    end
  end

endmodule

// File: rtl/bls_gather.sv
// bls_gather: merges the read taps of all cells into one word
// depends on bls_pkg
`timescale 1ns / 1ps

module bls_gather
  import bls_pkg::*;
#(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic [WORD_BITS-1:0] taps [CAPACITY],
  output logic [WORD_BITS-1:0] word
);

  // at most one tap is nonzero, so an or over the row selects it
  always_comb begin
    word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      word = word | taps[i];
    end
  end

endmodule

// File: rtl/bounded_list_store.sv
// bounded_list_store: top level, controller and the row of entry cells
// depends on bls_pkg, bls_cell, bls_gather
//
// usage
//   a request (action, index, element) is taken at a rising edge with start
//   high and busy low. busy is high while the accepted request is applied.
//   every request gives exactly one result: done is high for one cycle with
//   status, read_data, fill_count and has_more valid in that same cycle.
//   the receiver cannot stall; results must be taken when done is high.
//   done rises at the edge after the accepting edge. no new request is
//   taken while busy is high: the accepting edge latches the request and
//   captures the addressed entry into the cell read taps, the next edge
//   applies the command to the whole row at once (ordered removal shifts
//   the tail by one cell in that single edge) and registers the result.
//   capacity_limit is written through cfg_write / cfg_data; the user must
//   do so only while no request is in flight, as the block does not enforce
//   it. zero acts as 1 and values above CAPACITY act as CAPACITY.
//   reset (rst, synchronous) zeroes every entry, the count and the iterator
//   and sets capacity_limit to 64; a request may follow in the next cycle.
`timescale 1ns / 1ps

module bounded_list_store
  import bls_pkg::*;
#(
  parameter int CAPACITY  = DEF_CAPACITY,
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [ACTION_BITS-1:0] action,
  input  logic [INDEX_BITS-1:0]  index,
  input  logic [ELEM_BITS-1:0]   element,
  input  logic                   cfg_write,
  input  logic [CFG_BITS-1:0]    cfg_data,
  output logic                   done,
  output logic [1:0]             status,
  output logic [ELEM_BITS-1:0]   read_data,
  output logic [FILL_BITS-1:0]   fill_count,
  output logic                   has_more
);

  localparam int IDX_BITS = $clog2(CAPACITY);
  localparam int CNT_BITS = $clog2(CAPACITY + 1);
  localparam int CMP_BITS = (CNT_BITS > INDEX_BITS) ? CNT_BITS : INDEX_BITS;

  state_t                state;
  state_t                state_next;
  logic                  accept;
  logic                  apply;

  logic [CFG_BITS-1:0]   cap_cfg;
  logic [CMP_BITS-1:0]   cap_eff;
  logic [CMP_BITS-1:0]   cap_cfg_ext;

  logic [CNT_BITS-1:0]   count;
  logic [CNT_BITS-1:0]   count_next;
  logic [CNT_BITS-1:0]   count_m1;
  logic [CNT_BITS-1:0]   iter;
  logic [CNT_BITS-1:0]   iter_next;

  logic [ACTION_BITS-1:0] req_action;
  logic [INDEX_BITS-1:0]  req_index;
  logic [WORD_BITS-1:0]   req_word;

  logic [CMP_BITS-1:0]   in_idx_ext;
  logic [CMP_BITS-1:0]   idx_ext;
  logic [CMP_BITS-1:0]   idx_plus;
  logic [CMP_BITS-1:0]   count_ext;
  logic [CMP_BITS-1:0]   cnt_next_ext;
  logic [MAX_WORD_BITS-1:0] elem_wide;
  logic [MAX_WORD_BITS-1:0] rd_wide;

  logic [IDX_BITS-1:0]   rd_addr;
  logic [IDX_BITS-1:0]   wr_addr;
  logic [IDX_BITS-1:0]   last_addr;
  logic [WORD_BITS-1:0]  wr_word;
  logic [WORD_BITS-1:0]  gathered;
  logic [WORD_BITS-1:0]  rdata_next;
  status_t               status_next;
  cell_op_t              op_sel;
  cell_ctrl_t            ctrl;

  logic [WORD_BITS-1:0]  cell_data [CAPACITY];
  logic [WORD_BITS-1:0]  cell_tap  [CAPACITY];

  // controller state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and handshake
  always_comb begin
    state_next = state;
    busy       = 1'b0;
    accept     = 1'b0;
    apply      = 1'b0;
    unique case (state)
      S_IDLE: begin
        accept = start;
        if (start) state_next = S_APPLY;
      end
      S_APPLY: begin
        busy       = 1'b1;
        apply      = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // capacity register and its effective value
  always_ff @(posedge clk) begin
    if (rst) begin
      cap_cfg <= CFG_RESET;
    end else if (cfg_write) begin
      cap_cfg <= cfg_data;
    end
  end

  assign cap_cfg_ext = CMP_BITS'(cap_cfg);

  always_comb begin
    if (cap_cfg == '0) cap_eff = CMP_BITS'(1);
    else if (cap_cfg_ext > CMP_BITS'(CAPACITY)) cap_eff = CMP_BITS'(CAPACITY);
    else cap_eff = cap_cfg_ext;
  end

  // request latch
  assign elem_wide = MAX_WORD_BITS'(element);

  always_ff @(posedge clk) begin
    if (accept) begin
      req_action <= action;
      req_index  <= index;
      req_word   <= elem_wide[WORD_BITS-1:0];
    end
  end

  assign count_m1   = count - CNT_BITS'(1);
  assign count_ext  = CMP_BITS'(count);
  assign in_idx_ext = CMP_BITS'(index);
  assign idx_ext    = CMP_BITS'(req_index);
  assign idx_plus   = idx_ext + CMP_BITS'(1);

  // read address for the tap capture at the accepting edge
  always_comb begin
    if (action == ACT_NEXT) rd_addr = iter[IDX_BITS-1:0];
    else if (action == ACT_REM_UNORD) rd_addr = count_m1[IDX_BITS-1:0];
    else rd_addr = in_idx_ext[IDX_BITS-1:0];
  end

  // operation decode while applying
  always_comb begin
    status_next = ST_OK;
    rdata_next  = '0;
    count_next  = count;
    iter_next   = iter;
    op_sel      = C_HOLD;
    wr_addr     = idx_ext[IDX_BITS-1:0];
    wr_word     = req_word;
    last_addr   = count_m1[IDX_BITS-1:0];
    case (req_action)
      ACT_SET: begin
        if (idx_ext >= cap_eff) begin
          status_next = ST_RANGE;
        end else begin
          op_sel = C_WRITE;
          if (idx_ext >= count_ext) count_next = idx_plus[CNT_BITS-1:0];
        end
      end
      ACT_PUSH: begin
        if (count_ext >= cap_eff) begin
          status_next = ST_FULL;
        end else begin
          op_sel     = C_WRITE;
          wr_addr    = count[IDX_BITS-1:0];
          count_next = count + CNT_BITS'(1);
        end
      end
      ACT_POP: begin
        if (count != '0) begin
          op_sel     = C_ZERO_LAST;
          count_next = count_m1;
        end
      end
      ACT_REM_ORD: begin
        if (idx_ext >= count_ext) begin
          status_next = ST_RANGE;
        end else begin
          op_sel     = C_SHIFT;
          count_next = count_m1;
        end
      end
      ACT_REM_UNORD: begin
        if (idx_ext >= count_ext) begin
          status_next = ST_RANGE;
        end else begin
          op_sel     = C_MOVE;
          wr_word    = gathered;
          count_next = count_m1;
        end
      end
      ACT_GET: begin
        if (idx_ext >= cap_eff) status_next = ST_RANGE;
        else rdata_next = gathered;
      end
      ACT_CLEAR: begin
        op_sel     = C_CLEAR;
        count_next = '0;
      end
      ACT_ITER_RESET: begin
        iter_next = '0;
      end
      ACT_NEXT: begin
        if (iter < count) begin
          rdata_next = gathered;
          iter_next  = iter + CNT_BITS'(1);
        end else begin
          status_next = ST_END;
        end
      end
      default: begin
        op_sel = C_HOLD;
      end
    endcase
  end

  assign ctrl.op      = apply ? op_sel : C_HOLD;
  assign ctrl.capture = accept;

  // count and iterator
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      iter  <= '0;
    end else if (apply) begin
      count <= count_next;
      iter  <= iter_next;
    end
  end

  // result registers
  assign rd_wide      = MAX_WORD_BITS'(rdata_next);
  assign cnt_next_ext = CMP_BITS'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= apply;
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      status     <= status_next;
      read_data  <= rd_wide[ELEM_BITS-1:0];
      fill_count <= cnt_next_ext[FILL_BITS-1:0];
      has_more   <= (iter_next < count_next);
    end
  end

  // row of entry cells, each linked to its right neighbor
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_BITS-1:0] right_data;
    if (g == CAPACITY - 1) begin : g_end
      assign right_data = '0;
    end else begin : g_mid
      assign right_data = cell_data[g+1];
    end
    bls_cell #(
      .POS       (g),
      .IDX_BITS  (IDX_BITS),
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .wr_addr    (wr_addr),
      .last_addr  (last_addr),
      .rd_addr    (rd_addr),
      .wr_word    (wr_word),
      .right_data (right_data),
      .data       (cell_data[g]),
      .tap        (cell_tap[g])
    );
  end

  // merge of the read taps
  bls_gather #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_gather (
    .taps (cell_tap),
    .word (gathered)
  );

endmodule
